@@ rtl/mailbox_multi_queue_fifo_assert.svh @@
// Assertion macros shared by the mailbox queue RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef MAILBOX_MULTI_QUEUE_FIFO_ASSERT_SVH
`define MAILBOX_MULTI_QUEUE_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MMQF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mmqf: implication check failed");
// Next-cycle implication.
`define MMQF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mmqf: next-cycle check failed");
// Condition that must never hold.
`define MMQF_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("mmqf: forbidden condition seen");
`else
`define MMQF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MMQF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define MMQF_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ rtl/mmqf_pkg.sv @@
// Shared types and constants of the mailbox queue block.
// Depends on nothing; imported by the front end, the back end and the top level.
package mmqf_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned BoxPortW = 4;
  localparam int unsigned MsgPortW = 64;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef enum logic {
    KindEnq = 1'b0,
    KindDeq = 1'b1
  } kind_e;

  // What the back end has to do with one classified item.
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_e status;
  } cmd_ctrl_t;

endpackage

@@ rtl/mmqf_front.sv @@
// Front end: accepts operations, keeps per-mailbox head, tail and count,
// and issues memory commands. Depends on mmqf_pkg and the assertion header.
`include "mailbox_multi_queue_fifo_assert.svh"

module mmqf_front
  import mmqf_pkg::*;
#(
  parameter int unsigned NUM_MAILBOXES = 16,
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned MSG_WIDTH     = 64
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  input  logic                                        in_kind_i,
  input  logic [BoxPortW-1:0]                         in_mailbox_i,
  input  logic [MsgPortW-1:0]                         in_msg_i,
  output logic                                        in_ready_o,
  input  logic                                        q_full_i,
  output logic                                        push_o,
  output cmd_ctrl_t                                   ctrl_o,
  output logic [((NUM_MAILBOXES < (2**BoxPortW)) ?
                 ((NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1) :
                 BoxPortW) + $clog2(QUEUE_DEPTH) - 1:0] addr_o,
  output logic [MSG_WIDTH-1:0]                        data_o
);

  localparam int unsigned NumBoxes = (NUM_MAILBOXES < (2**BoxPortW)) ?
                                     NUM_MAILBOXES : (2**BoxPortW);
  localparam int unsigned BoxW = (NumBoxes > 1) ? $clog2(NumBoxes) : 1;
  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [BoxPortW:0] NumBoxesC = (BoxPortW + 1)'(NumBoxes);

  logic [PtrW-1:0] head_q [NumBoxes];
  logic [PtrW-1:0] tail_q [NumBoxes];
  logic [CntW-1:0] cnt_q  [NumBoxes];

  logic [BoxW-1:0] idx;
  logic            in_range;
  logic [PtrW-1:0] head_sel, tail_sel, head_d, tail_d;
  logic [CntW-1:0] cnt_sel, cnt_d;
  logic            is_enq, enq_ok, deq_ok;

  assign idx      = in_mailbox_i[BoxW-1:0];
  assign in_range = {1'b0, in_mailbox_i} < NumBoxesC;
  assign head_sel = in_range ? head_q[idx] : '0;
  assign tail_sel = in_range ? tail_q[idx] : '0;
  assign cnt_sel  = in_range ? cnt_q[idx]  : '0;

  assign is_enq = (in_kind_i == KindEnq);
  assign enq_ok = is_enq && in_range && (cnt_sel != CntW'(QUEUE_DEPTH));
  assign deq_ok = !is_enq && in_range && (cnt_sel != '0);

  // Pointers wrap at the queue depth, which need not be a power of two.
  assign tail_d = !enq_ok ? tail_sel :
                  (tail_sel == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + PtrW'(1);
  assign head_d = !deq_ok ? head_sel :
                  (head_sel == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PtrW'(1);
  assign cnt_d  = enq_ok ? cnt_sel + CntW'(1) :
                  deq_ok ? cnt_sel - CntW'(1) : cnt_sel;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    ctrl_o.wr     = enq_ok;
    ctrl_o.rd     = deq_ok;
    ctrl_o.status = is_enq ? (enq_ok ? StOk : StFull) : (deq_ok ? StOk : StEmpty);
  end

  assign addr_o = {idx, is_enq ? tail_sel : head_sel};
  assign data_o = in_msg_i[MSG_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBoxes; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (push_o && (enq_ok || deq_ok)) begin
      head_q[idx] <= head_d;
      tail_q[idx] <= tail_d;
      cnt_q[idx]  <= cnt_d;
    end
  end

  `MMQF_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_sel > CntW'(QUEUE_DEPTH))
  `MMQF_ASSERT_NEVER(a_wr_rd_excl, clk_i, rst_ni, ctrl_o.wr && ctrl_o.rd)
  `MMQF_ASSERT_IMP(a_full_on_enq, clk_i, rst_ni, push_o && (ctrl_o.status == StFull), is_enq)

endmodule

@@ rtl/mmqf_cmd_fifo.sv @@
// Two-entry command queue between the front and the back end.
// Depends on the assertion header only.
`include "mailbox_multi_queue_fifo_assert.svh"

module mmqf_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned Depth = 2;

  logic [WIDTH-1:0] slot_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  `MMQF_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `MMQF_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o)
  `MMQF_ASSERT_NXT(a_ptr_gap, clk_i, rst_ni, cnt_q == 2'd1, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))

endmodule

@@ rtl/mmqf_back.sv @@
// Back end: message memory access and the result register.
// Depends on mmqf_pkg.
module mmqf_back
  import mmqf_pkg::*;
#(
  parameter int unsigned NUM_MAILBOXES = 16,
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned MSG_WIDTH     = 64
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        q_valid_i,
  input  cmd_ctrl_t                                   ctrl_i,
  input  logic [((NUM_MAILBOXES < (2**BoxPortW)) ?
                 ((NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1) :
                 BoxPortW) + $clog2(QUEUE_DEPTH) - 1:0] addr_i,
  input  logic [MSG_WIDTH-1:0]                        data_i,
  output logic                                        q_pop_o,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [1:0]                                  out_status_o,
  output logic [MsgPortW-1:0]                         out_msg_o
);

  localparam int unsigned NumBoxes = (NUM_MAILBOXES < (2**BoxPortW)) ?
                                     NUM_MAILBOXES : (2**BoxPortW);
  localparam int unsigned PtrW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned MemDepth = NumBoxes * (2**PtrW);

  logic [MSG_WIDTH-1:0] msg_mem_q [MemDepth];
  logic [MSG_WIDTH-1:0] rdata_q;
  logic                 rd_flag_q;
  status_e              status_q;
  logic                 out_valid_q;
  logic                 advance;

  // The result register frees up when it is empty or being taken.
  assign advance = !out_valid_q || out_ready_i;
  assign q_pop_o = q_valid_i && advance;

  always_ff @(posedge clk_i) begin
    if (q_pop_o && ctrl_i.wr) begin
      msg_mem_q[addr_i] <= data_i;
    end
    if (q_pop_o && ctrl_i.rd) begin
      rdata_q <= msg_mem_q[addr_i];
    end
    if (q_pop_o) begin
      rd_flag_q <= ctrl_i.rd;
      status_q  <= ctrl_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= q_valid_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_msg_o    = rd_flag_q ? MsgPortW'(rdata_q) : '0;

endmodule

@@ rtl/mailbox_multi_queue_fifo.sv @@
// Top level of the mailbox queue block: a bank of circular message queues.
// Depends on mmqf_pkg, mmqf_front, mmqf_cmd_fifo and mmqf_back.
//
// Usage
//   The slave stream carries one operation per beat. tuser selects the
//   operation (0 enqueue, 1 dequeue) and tdata names the mailbox and, for an
//   enqueue, the message. The master stream returns exactly one result beat
//   per operation, in order: a status code and the dequeued message, which
//   is zero for an enqueue and for an error.
//   Status 1 means the mailbox was full on enqueue, status 2 that it was
//   empty on dequeue; a mailbox index at or above NUM_MAILBOXES fails the
//   same way. A failed operation changes no state.
// Timing
//   The block takes one beat per cycle while tready is high. The front end looks up and updates
//   the addressed mailbox's head, tail and count in the cycle of acceptance,
//   so back-to-back operations on one mailbox see each other at once. The
//   result beat passes through two registers in order: the command queue slot, then
//   the result register, which the back end loads through the memory port.
// Reset and stall
//   Reset empties every mailbox and the internal queues; the message memory
//   is not cleared and needs no clearing pass. When the receiver stalls, the
//   result register holds its beat, the two-entry command queue fills, and
//   tready then drops until the result is taken.
module mailbox_multi_queue_fifo
  import mmqf_pkg::*;
#(
  parameter int unsigned NUM_MAILBOXES = 16,
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned MSG_WIDTH     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, lowest bit up: mailbox [3:0], message_in [67:4], zero pad [71:68]
  input  logic [71:0] s_axis_tdata,
  // tuser: kind [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, lowest bit up: status [1:0], message_out [65:2], zero pad [71:66]
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned NumBoxes = (NUM_MAILBOXES < (2**BoxPortW)) ?
                                     NUM_MAILBOXES : (2**BoxPortW);
  localparam int unsigned BoxW  = (NumBoxes > 1) ? $clog2(NumBoxes) : 1;
  localparam int unsigned AddrW = BoxW + $clog2(QUEUE_DEPTH);
  localparam int unsigned CtrlW = $bits(cmd_ctrl_t);
  localparam int unsigned QW    = CtrlW + AddrW + MSG_WIDTH;

  logic                 q_full, push, q_valid, q_pop;
  cmd_ctrl_t            push_ctrl, pop_ctrl;
  logic [AddrW-1:0]     push_addr, pop_addr;
  logic [MSG_WIDTH-1:0] push_data, pop_data;
  logic [QW-1:0]        push_word, pop_word;
  logic [1:0]           res_status;
  logic [MsgPortW-1:0]  res_msg;

  mmqf_front #(
    .NUM_MAILBOXES(NUM_MAILBOXES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MSG_WIDTH    (MSG_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_mailbox_i(s_axis_tdata[BoxPortW-1:0]),
    .in_msg_i    (s_axis_tdata[BoxPortW +: MsgPortW]),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .push_o      (push),
    .ctrl_o      (push_ctrl),
    .addr_o      (push_addr),
    .data_o      (push_data)
  );

  // Command word packing: control on top, then address, then message.
  assign push_word = {push_ctrl, push_addr, push_data};
  assign pop_ctrl  = cmd_ctrl_t'(pop_word[QW-1 -: CtrlW]);
  assign pop_addr  = pop_word[MSG_WIDTH +: AddrW];
  assign pop_data  = pop_word[MSG_WIDTH-1:0];

  mmqf_cmd_fifo #(
    .WIDTH(QW)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_word),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (pop_word)
  );

  mmqf_back #(
    .NUM_MAILBOXES(NUM_MAILBOXES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MSG_WIDTH    (MSG_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .ctrl_i      (pop_ctrl),
    .addr_i      (pop_addr),
    .data_i      (pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(res_status),
    .out_msg_o   (res_msg)
  );

  assign m_axis_tdata = {6'b0, res_msg, res_status};

endmodule
